// File: sv/vtr_pkg.sv
// Shared types, codes and helpers for the vector and tensor rotation block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package vtr_pkg;

  // Width of the element index tag carried alongside each item
  localparam int INDEX_WIDTH = 24;
  localparam int CFG_WIDTH   = 48;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_POINT  = 2'd0,
    MODE_VECTOR = 2'd1,
    MODE_FULL   = 2'd2,
    MODE_SYM    = 2'd3
  } mode_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_SHIFT_X  = 3'd3,
    REG_SHIFT_Y  = 3'd4,
    REG_SHIFT_Z  = 3'd5
  } cfg_reg_t;

  // Identity rows after reset (1.0 in Q1.14 on the diagonal)
  localparam logic [CFG_WIDTH-1:0] ROW0_RESET = 48'h0000_0000_4000;
  localparam logic [CFG_WIDTH-1:0] ROW1_RESET = 48'h0000_4000_0000;
  localparam logic [CFG_WIDTH-1:0] ROW2_RESET = 48'h4000_0000_0000;

  // Rounding constant: half of one Q16.16 step after a 14-bit shift
  localparam int RND_HALF = 8192;

  typedef logic signed [15:0] coef_t;   // Q1.14 coefficient
  typedef logic signed [31:0] comp_t;   // Q16.16 component
  typedef logic signed [34:0] mid_t;    // rounded first-pass term
  typedef logic signed [35:0] vec_t;    // vector result plus translation
  typedef logic signed [38:0] wide_t;   // rounded second-pass term
  typedef logic signed [47:0] prod1_t;  // coefficient times component
  typedef logic signed [50:0] prod2_t;  // coefficient times first-pass term

  typedef coef_t coef_mat_t [3][3];
  typedef comp_t comp_mat_t [3][3];
  typedef mid_t  mid_mat_t  [3][3];
  typedef comp_t comp_vec3_t [3];
  typedef comp_t res_vec_t  [9];

  // Load enables for a product stage and the register after it
  typedef struct packed {
    logic en_prod;
    logic en_sum;
  } stage_en_t;

  // Clamp to the signed 32-bit range
  function automatic comp_t sat32(input wide_t x);
    comp_t r;
    if (x > 39'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -39'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/vector_and_tensor_rotation.sv
// Top level of the vector and tensor rotation block: configuration registers,
// input stage, handshake control; uses vtr_pkg, vtr_rot_a and vtr_rot_b.
//
// Usage:
//   Input channel in_valid / in_stall carries mode, element_index, comp0..8.
//   Output channel out_valid / out_stall carries result_index and res0..8.
//   An item moves at a clock edge where valid is high and stall is low.
//   The pipeline has five register stages: input, first products, first
//   rounded sums, second products, output. One item per cycle is sustained
//   while out_stall is low; that rate comes from the two product stages,
//   each with 27 multipliers of its own.
//   When out_stall holds, the output register keeps its result and the
//   stages behind it keep filling until every stage holds an item; only then
//   is in_stall raised. No item is lost or repeated across a stall.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
//   the user must make them while the pipeline is empty, the block does not enforce it.
//   Synchronous reset empties the pipeline and loads the identity rotation
//   with zero translation.
`default_nettype none

module vector_and_tensor_rotation import vtr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [INDEX_WIDTH-1:0] element_index,
  input  logic signed [31:0]     comp0,
  input  logic signed [31:0]     comp1,
  input  logic signed [31:0]     comp2,
  input  logic signed [31:0]     comp3,
  input  logic signed [31:0]     comp4,
  input  logic signed [31:0]     comp5,
  input  logic signed [31:0]     comp6,
  input  logic signed [31:0]     comp7,
  input  logic signed [31:0]     comp8,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [INDEX_WIDTH-1:0] result_index,
  output logic signed [31:0]     res0,
  output logic signed [31:0]     res1,
  output logic signed [31:0]     res2,
  output logic signed [31:0]     res3,
  output logic signed [31:0]     res4,
  output logic signed [31:0]     res5,
  output logic signed [31:0]     res6,
  output logic signed [31:0]     res7,
  output logic signed [31:0]     res8
);

  logic [CFG_WIDTH-1:0] rot_row [3];
  comp_vec3_t shift;
  coef_mat_t  coef;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  mode_t mode1, mode2, mode3, mode4, mode5;
  logic [INDEX_WIDTH-1:0] idx1, idx2, idx3, idx4;
  comp_mat_t tens1;
  comp_mat_t tens_next;
  mid_mat_t  umat;
  res_vec_t  res;
  stage_en_t en_a, en_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= ROW0_RESET;
      rot_row[1] <= ROW1_RESET;
      rot_row[2] <= ROW2_RESET;
      shift[0]   <= '0;
      shift[1]   <= '0;
      shift[2]   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROT_ROW0: rot_row[0] <= cfg_data;
        REG_ROT_ROW1: rot_row[1] <= cfg_data;
        REG_ROT_ROW2: rot_row[2] <= cfg_data;
        REG_SHIFT_X:  shift[0]   <= cfg_data[31:0];
        REG_SHIFT_Y:  shift[1]   <= cfg_data[31:0];
        REG_SHIFT_Z:  shift[2]   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients, column 0 lowest
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = rot_row[r][16*c +: 16];
      end
    end
  end

  // Stage enables: a stage advances when empty or when the next one advances
  assign en5 = !out_valid || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  assign en_a = '{en_prod: en2, en_sum: en3};
  assign en_b = '{en_prod: en4, en_sum: en5};

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // Arrange components as a 3x3 matrix; vectors sit in row 0
  always_comb begin
    tens_next[0][0] = comp0;
    tens_next[0][1] = comp1;
    tens_next[0][2] = comp2;
    tens_next[1][0] = comp3;
    tens_next[1][1] = comp4;
    tens_next[1][2] = comp5;
    tens_next[2][0] = comp6;
    tens_next[2][1] = comp7;
    tens_next[2][2] = comp8;
    if (mode_t'(mode) == MODE_SYM) begin
      tens_next[0][0] = comp0;
      tens_next[1][1] = comp1;
      tens_next[2][2] = comp2;
      tens_next[0][1] = comp3;
      tens_next[1][0] = comp3;
      tens_next[1][2] = comp4;
      tens_next[2][1] = comp4;
      tens_next[0][2] = comp5;
      tens_next[2][0] = comp5;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (en1) begin
      mode1 <= mode_t'(mode);
      idx1  <= element_index;
      tens1 <= tens_next;
    end
  end

  // Carry mode and tag alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en2) begin
      mode2 <= mode1;
      idx2  <= idx1;
    end
    if (en3) begin
      mode3 <= mode2;
      idx3  <= idx2;
    end
    if (en4) begin
      mode4 <= mode3;
      idx4  <= idx3;
    end
    if (en5) begin
      mode5        <= mode4;
      result_index <= idx4;
    end
  end

  vtr_rot_a u_rot_a (
    .clk  (clk),
    .en   (en_a),
    .coef (coef),
    .tens (tens1),
    .umat (umat)
  );

  vtr_rot_b u_rot_b (
    .clk      (clk),
    .en       (en_b),
    .coef     (coef),
    .umat     (umat),
    .shift    (shift),
    .mode_in  (mode3),
    .mode_out (mode4),
    .res      (res)
  );

  assign res0 = res[0];
  assign res1 = res[1];
  assign res2 = res[2];
  assign res3 = res[3];
  assign res4 = res[4];
  assign res5 = res[5];
  assign res6 = res[6];
  assign res7 = res[7];
  assign res8 = res[8];

  // Input is held back only when every stage is full and the output waits
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // An accepted item lands in the input stage
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted item missing from input stage");

  // Only full tensors produce the last three components
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode5 != MODE_FULL) |-> (res6 == 0 && res7 == 0 && res8 == 0))
    else $error("unused result components not zero");

  // Vector kinds leave the off-diagonal slots clear
  a_vector_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mode5 == MODE_POINT || mode5 == MODE_VECTOR))
      |-> (res3 == 0 && res4 == 0 && res5 == 0))
    else $error("vector result carries tensor components");

endmodule

`default_nettype wire

// File: sv/vtr_rot_a.sv
// First matrix pass: U[k][j] = round(sum_l M[j][l] * T[k][l]).
// One product register stage and one rounded-sum register stage; uses vtr_pkg.
`default_nettype none

module vtr_rot_a import vtr_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  coef_mat_t coef,
  input  comp_mat_t tens,
  output mid_mat_t  umat
);

  prod1_t prod [3][3][3];
  logic signed [49:0] acc [3][3];

  // Register all 27 products
  always_ff @(posedge clk) begin
    if (en.en_prod) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          for (int l = 0; l < 3; l++) begin
            prod[k][j][l] <= coef[j][l] * tens[k][l];
          end
        end
      end
    end
  end

  // Sum three products and add the rounding half
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        acc[k][j] = 50'(prod[k][j][0]) + 50'(prod[k][j][1]) + 50'(prod[k][j][2])
                  + 50'(RND_HALF);
      end
    end
  end

  // Drop 14 fraction bits, keep full width
  always_ff @(posedge clk) begin
    if (en.en_sum) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          umat[k][j] <= acc[k][j][48:14];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/vtr_rot_b.sv
// Second matrix pass R[i][j] = round(sum_k M[i][k] * U[k][j]), the vector path
// with translation, saturation and the output mapping by mode; uses vtr_pkg.
`default_nettype none

module vtr_rot_b import vtr_pkg::*; (
  input  logic       clk,
  input  stage_en_t  en,
  input  coef_mat_t  coef,
  input  mid_mat_t   umat,
  input  comp_vec3_t shift,
  input  mode_t      mode_in,
  input  mode_t      mode_out,
  output res_vec_t   res
);

  prod2_t prod [3][3][3];
  vec_t   vec  [3];
  logic signed [52:0] acc [3][3];
  comp_t  rsat [3][3];
  comp_t  vsat [3];
  res_vec_t res_next;

  // Register products; the vector result rides along, with the translation added for points
  always_ff @(posedge clk) begin
    if (en.en_prod) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            prod[i][j][k] <= coef[i][k] * umat[k][j];
          end
        end
      end
      for (int j = 0; j < 3; j++) begin
        if (mode_in == MODE_POINT) begin
          vec[j] <= 36'(umat[0][j]) + 36'(shift[j]);
        end else begin
          vec[j] <= 36'(umat[0][j]);
        end
      end
    end
  end

  // Round, saturate and place results by mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc[i][j] = 53'(prod[i][j][0]) + 53'(prod[i][j][1]) + 53'(prod[i][j][2])
                  + 53'(RND_HALF);
        rsat[i][j] = sat32(acc[i][j][52:14]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      vsat[j] = sat32(39'(vec[j]));
    end
    for (int n = 0; n < 9; n++) begin
      res_next[n] = '0;
    end
    case (mode_out)
      MODE_FULL: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            res_next[3*i+j] = rsat[i][j];
          end
        end
      end
      MODE_SYM: begin
        res_next[0] = rsat[0][0];
        res_next[1] = rsat[1][1];
        res_next[2] = rsat[2][2];
        res_next[3] = rsat[1][0];
        res_next[4] = rsat[2][1];
        res_next[5] = rsat[2][0];
      end
      default: begin
        for (int j = 0; j < 3; j++) begin
          res_next[j] = vsat[j];
        end
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en.en_sum) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: tb/rotation_checker.sv
`timescale 1ns / 100ps
// Result checker for vector_and_tensor_rotation: follows register writes, works out
// each transformed item and compares the results in order. Depends on vtr_pkg.
module rotation_checker import vtr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [INDEX_WIDTH-1:0] element_index,
  input  logic [31:0]            comp0,
  input  logic [31:0]            comp1,
  input  logic [31:0]            comp2,
  input  logic [31:0]            comp3,
  input  logic [31:0]            comp4,
  input  logic [31:0]            comp5,
  input  logic [31:0]            comp6,
  input  logic [31:0]            comp7,
  input  logic [31:0]            comp8,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [INDEX_WIDTH-1:0] result_index,
  input  logic [31:0]            res0,
  input  logic [31:0]            res1,
  input  logic [31:0]            res2,
  input  logic [31:0]            res3,
  input  logic [31:0]            res4,
  input  logic [31:0]            res5,
  input  logic [31:0]            res6,
  input  logic [31:0]            res7,
  input  logic [31:0]            res8,
  output int                     mismatches,
  output int                     outstanding
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] tag;
    logic [8:0][31:0]       val;
  } rotated_t;

  logic [CFG_WIDTH-1:0] rot_rows [3];
  comp_t                offsets [3];
  rotated_t             rotated_q [$];

  // Signed Q1.14 coefficient of row r, column k
  function automatic longint coef_at(input int r, input int k);
    return longint'(coef_t'(rot_rows[r][16*k +: 16]));
  endfunction

  // Round half up, then floor-shift back to Q16.16
  function automatic longint round_q14(input longint x);
    return (x + longint'(RND_HALF)) >>> 14;
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > Q_MAX) return 32'h7FFF_FFFF;
    if (x < Q_MIN) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Transform one item under the current rotation and translation
  function automatic rotated_t rotate_item(input logic [1:0] kind,
                                           input logic [INDEX_WIDTH-1:0] tag,
                                           input logic [8:0][31:0] c);
    rotated_t out_item;
    longint   x [9];
    longint   t [3][3];
    longint   u [3][3];
    longint   r [3][3];
    longint   s;
    int       i, j, k;
    out_item     = '0;
    out_item.tag = tag;
    for (i = 0; i < 9; i++) x[i] = longint'($signed(c[i]));
    case (mode_t'(kind))
      MODE_POINT, MODE_VECTOR: begin
        for (i = 0; i < 3; i++) begin
          s = 0;
          for (j = 0; j < 3; j++) s += coef_at(i, j) * x[j];
          s = round_q14(s);
          if (kind == MODE_POINT) s += longint'(offsets[i]);
          out_item.val[i] = clamp32(s);
        end
      end
      default: begin
        if (kind == MODE_FULL) begin
          for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++) t[i][j] = x[3*i + j];
        end else begin
          // symmetric storage: 11, 22, 33, 12, 23, 13
          t[0][0] = x[0]; t[1][1] = x[1]; t[2][2] = x[2];
          t[0][1] = x[3]; t[1][0] = x[3];
          t[1][2] = x[4]; t[2][1] = x[4];
          t[0][2] = x[5]; t[2][0] = x[5];
        end
        // first pass T*M^T, rounded but kept wide
        for (k = 0; k < 3; k++)
          for (j = 0; j < 3; j++) begin
            s = 0;
            for (i = 0; i < 3; i++) s += coef_at(j, i) * t[k][i];
            u[k][j] = round_q14(s);
          end
        // second pass M*U
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++) begin
            s = 0;
            for (k = 0; k < 3; k++) s += coef_at(i, k) * u[k][j];
            r[i][j] = round_q14(s);
          end
        if (kind == MODE_FULL) begin
          for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++) out_item.val[3*i + j] = clamp32(r[i][j]);
        end else begin
          // diagonal first, then the lower triangle
          out_item.val[0] = clamp32(r[0][0]);
          out_item.val[1] = clamp32(r[1][1]);
          out_item.val[2] = clamp32(r[2][2]);
          out_item.val[3] = clamp32(r[1][0]);
          out_item.val[4] = clamp32(r[2][1]);
          out_item.val[5] = clamp32(r[2][0]);
        end
      end
    endcase
    return out_item;
  endfunction

  // Track registers, compare taken results, queue predictions for taken items
  always @(posedge clk) begin
    rotated_t    want;
    logic [31:0] got [9];
    int          i;
    if (rst) begin
      rot_rows[0] <= ROW0_RESET;
      rot_rows[1] <= ROW1_RESET;
      rot_rows[2] <= ROW2_RESET;
      offsets[0]  <= '0;
      offsets[1]  <= '0;
      offsets[2]  <= '0;
      rotated_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROT_ROW0: rot_rows[0] <= cfg_data;
          REG_ROT_ROW1: rot_rows[1] <= cfg_data;
          REG_ROT_ROW2: rot_rows[2] <= cfg_data;
          REG_SHIFT_X:  offsets[0]  <= cfg_data[31:0];
          REG_SHIFT_Y:  offsets[1]  <= cfg_data[31:0];
          REG_SHIFT_Z:  offsets[2]  <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{res0, res1, res2, res3, res4, res5, res6, res7, res8};
        if (rotated_q.size() == 0) begin
          $error("result with result_index %0h arrived with nothing expected", result_index);
          mismatches++;
        end else begin
          want = rotated_q.pop_front();
          if (result_index !== want.tag) begin
            $error("result_index: expected %0h, got %0h", want.tag, result_index);
            mismatches++;
          end
          for (i = 0; i < 9; i++) begin
            if (got[i] !== want.val[i]) begin
              $error("res%0d: expected %0d, got %0d", i, $signed(want.val[i]),
                     $signed(got[i]));
              mismatches++;
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        rotated_q.push_back(rotate_item(mode, element_index,
          {comp8, comp7, comp6, comp5, comp4, comp3, comp2, comp1, comp0}));
      end
    end
    outstanding <= rotated_q.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for vector_and_tensor_rotation: directed and random items under
// several register settings, random idling on both sides. Uses rotation_checker.
module tb import vtr_pkg::*; ();

  localparam int TIMEOUT_CYCLES  = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_IDLE        = 11;
  localparam int BURST_LEN       = 40;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 84;
  localparam int ONE_Q14         = 16384;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum {SET_RANDOM, SET_ROTATION, SET_SMALL, SET_FULL_SCALE} setting_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [2:0]             cfg_index;
  logic [CFG_WIDTH-1:0]   cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             mode;
  logic [INDEX_WIDTH-1:0] element_index;
  logic signed [31:0]     comp0, comp1, comp2, comp3, comp4, comp5, comp6, comp7, comp8;
  logic                   out_valid;
  logic                   out_stall;
  logic [INDEX_WIDTH-1:0] result_index;
  logic signed [31:0]     res0, res1, res2, res3, res4, res5, res6, res7, res8;
  int                     mismatches;
  int                     outstanding;
  int                     tx_gap_max;
  int                     rx_stall_max;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  vector_and_tensor_rotation dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .element_index(element_index),
    .comp0(comp0), .comp1(comp1), .comp2(comp2), .comp3(comp3), .comp4(comp4),
    .comp5(comp5), .comp6(comp6), .comp7(comp7), .comp8(comp8),
    .out_valid(out_valid), .out_stall(out_stall), .result_index(result_index),
    .res0(res0), .res1(res1), .res2(res2), .res3(res3), .res4(res4),
    .res5(res5), .res6(res6), .res7(res7), .res8(res8)
  );

  rotation_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .element_index(element_index),
    .comp0(comp0), .comp1(comp1), .comp2(comp2), .comp3(comp3), .comp4(comp4),
    .comp5(comp5), .comp6(comp6), .comp7(comp7), .comp8(comp8),
    .out_valid(out_valid), .out_stall(out_stall), .result_index(result_index),
    .res0(res0), .res1(res1), .res2(res2), .res3(res3), .res4(res4),
    .res5(res5), .res6(res6), .res7(res7), .res8(res8),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Three Q1.14 coefficients, column 0 lowest
  function automatic logic [47:0] pack_row(input int a, input int b, input int d);
    return {16'(d), 16'(b), 16'(a)};
  endfunction

  function automatic logic [8:0][31:0] comps9(input logic [31:0] a0, a1, a2, a3, a4,
                                              a5, a6, a7, a8);
    return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  // Mix of full-range, small, medium and extreme component values
  function automatic logic [31:0] rand_comp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: return v;
      1: return {{16{v[15]}}, v[15:0]};
      2: return {{12{v[19]}}, v[19:0]};
      default: begin
        case (v[1:0])
          2'd0: return 32'h7FFF_FFFF;
          2'd1: return 32'h8000_0000;
          2'd2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [1:0] kind, input logic [INDEX_WIDTH-1:0] tag,
                           input logic [8:0][31:0] c);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= kind;
    element_index <= tag;
    comp0 <= c[0]; comp1 <= c[1]; comp2 <= c[2];
    comp3 <= c[3]; comp4 <= c[4]; comp5 <= c[5];
    comp6 <= c[6]; comp7 <= c[7]; comp8 <= c[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain the block, then write every register; spare indexes must be ignored
  task automatic program_setting(input logic [47:0] r0, r1, r2,
                                 input logic [31:0] sx, sy, sz);
    cfg_reg_t    order [6];
    logic [47:0] data [6];
    int          i;
    order = '{REG_ROT_ROW0, REG_ROT_ROW1, REG_ROT_ROW2,
              REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z};
    data  = '{r0, r1, r2, {16'($urandom), sx}, {16'($urandom), sy}, {16'($urandom), sz}};
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE_LO;
    cfg_data  <= {16'($urandom), 32'($urandom)};
    @(posedge clk);
    for (i = 0; i < 6; i++) begin
      cfg_index <= order[i];
      cfg_data  <= data[i];
      @(posedge clk);
    end
    cfg_index <= REG_SPARE_HI;
    cfg_data  <= {16'($urandom), 32'($urandom)};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Pick a setting: true rotations, small or full-scale coefficients, or noise
  task automatic random_setting();
    setting_t    kind;
    logic [47:0] rows [3];
    logic [31:0] sh [3];
    logic [31:0] v;
    int          cs, sn, axis, i, j;
    int          cf [3];
    kind = setting_t'($urandom_range(0, 3));
    for (i = 0; i < 3; i++) begin
      v = $urandom;
      case (kind)
        SET_RANDOM:     sh[i] = v;
        SET_FULL_SCALE: sh[i] = v[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        default:        sh[i] = {{8{v[23]}}, v[23:0]};
      endcase
    end
    case (kind)
      SET_ROTATION: begin
        case ($urandom_range(0, 4))
          0: begin cs = ONE_Q14; sn = 0;       end
          1: begin cs = 14189;   sn = 8192;    end
          2: begin cs = 11585;   sn = 11585;   end
          3: begin cs = 0;       sn = ONE_Q14; end
          default: begin cs = -ONE_Q14; sn = 0; end
        endcase
        if ($urandom_range(0, 1) != 0) sn = -sn;
        axis = $urandom_range(0, 2);
        if (axis == 0) begin
          rows = '{pack_row(ONE_Q14, 0, 0), pack_row(0, cs, -sn), pack_row(0, sn, cs)};
        end else if (axis == 1) begin
          rows = '{pack_row(cs, 0, sn), pack_row(0, ONE_Q14, 0), pack_row(-sn, 0, cs)};
        end else begin
          rows = '{pack_row(cs, -sn, 0), pack_row(sn, cs, 0), pack_row(0, 0, ONE_Q14)};
        end
      end
      SET_SMALL: begin
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) cf[j] = $urandom_range(0, 511) - 256;
          rows[i] = pack_row(cf[0], cf[1], cf[2]);
        end
      end
      SET_FULL_SCALE: begin
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) begin
            case ($urandom_range(0, 3))
              0: cf[j] = 32767;
              1: cf[j] = -32768;
              2: cf[j] = 0;
              default: cf[j] = -1;
            endcase
          end
          rows[i] = pack_row(cf[0], cf[1], cf[2]);
        end
      end
      default: begin
        for (i = 0; i < 3; i++) rows[i] = {16'($urandom), 32'($urandom)};
      end
    endcase
    program_setting(rows[0], rows[1], rows[2], sh[0], sh[1], sh[2]);
  endtask

  // Receiver: random stall before each result, with stretches of none
  initial begin
    int wait_n;
    int taken;
    out_stall    = 1'b0;
    rx_stall_max = MAX_IDLE;
    taken        = 0;
    forever begin
      if (taken % BURST_LEN == 0) rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      wait_n = $urandom_range(0, rx_stall_max);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: end the run after too long without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < TIMEOUT_CYCLES) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || rst) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("vector_and_tensor_rotation verification failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int                 phase, n, k;
    logic [8:0][31:0]   c;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_ROT_ROW0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = MODE_POINT;
    element_index = '0;
    {comp0, comp1, comp2, comp3, comp4, comp5, comp6, comp7, comp8} = '0;
    tx_gap_max    = MAX_IDLE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // identity after reset; unused components must be ignored
    send_item(MODE_POINT, 24'h000000, comps9(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(MODE_VECTOR, 24'hFFFFFF, comps9(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000));
    send_item(MODE_FULL, 24'h5A5A5A, comps9(32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
              32'h1234_5678, 32'h8765_4321));
    send_item(MODE_SYM, 24'hA5A5A5, comps9(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
              32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(MODE_POINT, 24'h000001, '0);

    // largest positive coefficients and translation: saturation both ways
    program_setting(pack_row(32767, 32767, 32767), pack_row(32767, 32767, 32767),
                    pack_row(32767, 32767, 32767),
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(MODE_POINT, 24'h100000, {9{32'h7FFF_FFFF}});
    send_item(MODE_POINT, 24'h100001, {9{32'h8000_0000}});
    send_item(MODE_POINT, 24'h100002, '0);
    send_item(MODE_VECTOR, 24'h100003, comps9(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
              32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_item(MODE_FULL, 24'h100004, {9{32'h7FFF_FFFF}});
    send_item(MODE_SYM, 24'h100005, {9{32'h8000_0000}});

    // most negative coefficients and translation
    program_setting(pack_row(-32768, -32768, -32768), pack_row(-32768, -32768, -32768),
                    pack_row(-32768, -32768, -32768),
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(MODE_POINT, 24'h200000, {9{32'h7FFF_FFFF}});
    send_item(MODE_VECTOR, 24'h200001, {9{32'h8000_0000}});
    send_item(MODE_FULL, 24'h200002, comps9(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF));
    send_item(MODE_SYM, 24'h200003, comps9(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h0000_4000, 32'hFFFF_C000, 32'h0, 32'h0, 32'h0));
    send_item(MODE_POINT, 24'h200004, comps9(32'h1, 32'hFFFF_FFFF, 32'h0,
              32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));

    // unit-step coefficients: rounding exactly at half, above and below
    program_setting(pack_row(1, 0, 0), pack_row(0, -1, 0), pack_row(0, 0, 1),
                    32'h0, 32'h0001_0000, 32'hFFFF_FFFF);
    send_item(MODE_POINT, 24'h300000, comps9(32'd8192, 32'd8192, 32'd8191,
              32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_item(MODE_VECTOR, 24'h300001, comps9(-32'sd8192, -32'sd8193, 32'd24576,
              32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_item(MODE_FULL, 24'h300002, {9{32'h2000_2000}});

    // random items, a fresh setting for every phase
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting();
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % BURST_LEN == 0) tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
        for (k = 0; k < 9; k++) c[k] = rand_comp();
        send_item(2'($urandom_range(0, 3)), INDEX_WIDTH'($urandom), c);
      end
    end

    // let every result come out, then a little longer
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("vector_and_tensor_rotation verification clean");
    end else begin
      $display("vector_and_tensor_rotation verification failed");
    end
    $finish;
  end

endmodule
